FILE: rtl/mer_pkg.sv
// Shared types and constants for the midpoint ellipse rasterizer.
// Depends on nothing; the top level refers to it by scoped names.
`default_nettype none

package mer_pkg;

    // Width of the signed center coordinates.
    localparam int CENTER_W = 12;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_CENTER_X = 2'd0;
    localparam cfg_idx_t CFG_CENTER_Y = 2'd1;
    localparam cfg_idx_t CFG_RADIUS_X = 2'd2;
    localparam cfg_idx_t CFG_RADIUS_Y = 2'd3;

    // Walk phase of the current ellipse.
    typedef logic [1:0] phase_t;
    localparam phase_t PH_DONE = 2'd0;
    localparam phase_t PH_R1   = 2'd1;
    localparam phase_t PH_R2   = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer: one quadrant walk with four-way mirroring.
// Depends on mer_pkg for register indexes, phase codes and the center width.
//
// Channel   Dir  Handshake          Payload
// s_        in   tvalid / tready    tdata[0] = restart
// m_        out  tvalid / tready    tdata = point_x, point_y; tlast = last_of_step;
//                                   tuser = finished
// cfg_      in   wr_en (no wait)    cfg_index selects the register, cfg_wdata the value
//
// A restart request keeps the input busy while the radii are squared, a*a*b is formed,
// the walk is set up and both axis points are emitted; an advance squares the radii,
// steps the walk, updates the decision and emits four points, and entering region two
// adds the states that form the new decision. An advance after the end is taken and emits nothing.
// The work is paced by the single shared multiplier, used once per cycle, and by the output
// register, which takes one point a cycle unless stalled. Reset is synchronous, active low.
// A stalled output holds the sequencer in its emit state; no request is taken meanwhile.
`default_nettype none

module midpoint_ellipse_rasterizer #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 13
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input requests
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [0] restart
    // Plotted points
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]        m_tdata,   // point_x, then point_y
    output logic                                     m_tlast,   // last_of_step
    output logic                                     m_tuser,   // finished
    // Configuration writes
    input  wire logic                                cfg_wr_en,
    input  wire mer_pkg::cfg_idx_t                   cfg_index,
    input  wire logic [((RADIUS_BITS > mer_pkg::CENTER_W) ?
                        RADIUS_BITS : mer_pkg::CENTER_W)-1:0] cfg_wdata
);

    localparam int CW         = mer_pkg::CENTER_W;
    localparam int OPW        = 2*RADIUS_BITS + 2;
    localparam int PROD_W     = 2*OPW;
    localparam int DEC_RAW    = 4*RADIUS_BITS + 8;
    localparam int DEC_BITS   = (DEC_RAW > 64) ? 64 : DEC_RAW;
    localparam int SLOPE_BITS = 3*RADIUS_BITS + 4;
    localparam int STEP_BITS  = RADIUS_BITS + 2;
    localparam int SQ_W       = 2*RADIUS_BITS;
    localparam int DATA_W     = ((2*COORD_BITS+7)/8)*8;

    // Sequencer states.
    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_SQ_A    = 5'd1;
    localparam logic [4:0] ST_SQ_B    = 5'd2;
    localparam logic [4:0] ST_R_AB    = 5'd3;
    localparam logic [4:0] ST_R_AAB   = 5'd4;
    localparam logic [4:0] ST_R_INIT  = 5'd5;
    localparam logic [4:0] ST_STEP_A  = 5'd6;
    localparam logic [4:0] ST_STEP_B  = 5'd7;
    localparam logic [4:0] ST_CHK     = 5'd8;
    localparam logic [4:0] ST_SET_BT  = 5'd9;
    localparam logic [4:0] ST_SET_BT2 = 5'd10;
    localparam logic [4:0] ST_SET_AT  = 5'd11;
    localparam logic [4:0] ST_SET_AT2 = 5'd12;
    localparam logic [4:0] ST_SET_AB  = 5'd13;
    localparam logic [4:0] ST_SET_AB2 = 5'd14;
    localparam logic [4:0] ST_SET_END = 5'd15;
    localparam logic [4:0] ST_FIN     = 5'd16;
    localparam logic [4:0] ST_EMIT    = 5'd17;

    // Configuration registers.
    logic signed [CW-1:0]          center_x_reg, center_x_next;
    logic signed [CW-1:0]          center_y_reg, center_y_next;
    logic [RADIUS_BITS-1:0]        radius_x_reg, radius_x_next;
    logic [RADIUS_BITS-1:0]        radius_y_reg, radius_y_next;

    // Walk state.
    logic signed [STEP_BITS-1:0]   step_x_reg, step_x_next;
    logic signed [STEP_BITS-1:0]   step_y_reg, step_y_next;
    logic signed [SLOPE_BITS-1:0]  slope_x_reg, slope_x_next;
    logic signed [SLOPE_BITS-1:0]  slope_y_reg, slope_y_next;
    logic [DEC_BITS-1:0]           decision_reg, decision_next;
    mer_pkg::phase_t               phase_reg, phase_next;

    // Sequencer and working registers.
    logic [4:0]                    state_reg, state_next;
    logic                          restart_reg, restart_next;
    logic                          both_reg, both_next;
    logic                          fin_reg, fin_next;
    logic [1:0]                    k_reg, k_next;
    logic [SQ_W-1:0]               asq_reg, asq_next;
    logic [SQ_W-1:0]               bsq_reg, bsq_next;
    logic [DEC_BITS-1:0]           prod_reg, prod_next;
    logic [DEC_BITS-1:0]           acc_reg, acc_next;

    // Output register.
    logic                          m_valid_reg, m_valid_next;
    logic [COORD_BITS-1:0]         m_x_reg, m_x_next;
    logic [COORD_BITS-1:0]         m_y_reg, m_y_next;
    logic                          m_last_reg, m_last_next;
    logic                          m_fin_reg, m_fin_next;

    // Shared multiplier.
    logic [OPW-1:0]                mul_a, mul_b;
    logic [PROD_W-1:0]             mul_p;
    logic [DEC_BITS-1:0]           mul_dec;

    // Derived operands.
    logic [STEP_BITS-1:0]          tx_op, ty_abs;
    logic [DEC_BITS-1:0]           asq1, asq4, bsq4, p4, sx4, sy4, sx_ext, sy_ext;
    logic [SLOPE_BITS-1:0]         asq2_s, bsq2_s;
    logic                          dec_neg, emit_last, emit_load;
    logic [COORD_BITS-1:0]         cx_c, cy_c, sx_c, sy_c;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'({m_y_reg, m_x_reg});
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_fin_reg;

    // Operands of the region-two decision: 2x+1 and the magnitude of y-1.
    assign tx_op  = {step_x_reg[STEP_BITS-2:0], 1'b1};
    assign ty_abs = (step_y_reg == '0) ? STEP_BITS'(1) : STEP_BITS'(step_y_reg - 1'b1);

    // Scaled terms for the decision and slope updates.
    assign asq1   = DEC_BITS'(asq_reg);
    assign asq4   = asq1 << 2;
    assign bsq4   = DEC_BITS'(bsq_reg) << 2;
    assign p4     = prod_reg << 2;
    assign sx_ext = DEC_BITS'(slope_x_reg);
    assign sy_ext = DEC_BITS'(slope_y_reg);
    assign sx4    = sx_ext << 2;
    assign sy4    = sy_ext << 2;
    assign asq2_s = SLOPE_BITS'({asq_reg, 1'b0});
    assign bsq2_s = SLOPE_BITS'({bsq_reg, 1'b0});
    assign dec_neg = decision_reg[DEC_BITS-1];

    // Mirrored point for the current emit slot; coordinates wrap to COORD_BITS.
    assign cx_c = COORD_BITS'(center_x_reg);
    assign cy_c = COORD_BITS'(center_y_reg);
    assign sx_c = COORD_BITS'(step_x_reg);
    assign sy_c = COORD_BITS'(step_y_reg);
    assign emit_last = restart_reg ? (k_reg == 2'd1) : (k_reg == 2'd3);
    assign emit_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (state_reg)
            ST_SQ_A: begin
                mul_a = OPW'(radius_x_reg);
                mul_b = OPW'(radius_x_reg);
            end
            ST_SQ_B: begin
                mul_a = OPW'(radius_y_reg);
                mul_b = OPW'(radius_y_reg);
            end
            ST_R_AB, ST_SET_AB: begin
                mul_a = OPW'(radius_x_reg);
                mul_b = OPW'(radius_y_reg);
            end
            ST_R_AAB: begin
                mul_a = OPW'(radius_x_reg);
                mul_b = prod_reg[OPW-1:0];
            end
            ST_SET_BT: begin
                mul_a = OPW'(radius_y_reg);
                mul_b = OPW'(tx_op);
            end
            ST_SET_AT: begin
                mul_a = OPW'(radius_x_reg);
                mul_b = OPW'(ty_abs);
            end
            ST_SET_BT2, ST_SET_AT2, ST_SET_AB2: begin
                mul_a = prod_reg[OPW-1:0];
                mul_b = prod_reg[OPW-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign mul_dec = DEC_BITS'(mul_p);

    // Sequencer and datapath next-state logic.
    always_comb begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        radius_x_next = radius_x_reg;
        radius_y_next = radius_y_reg;
        step_x_next   = step_x_reg;
        step_y_next   = step_y_reg;
        slope_x_next  = slope_x_reg;
        slope_y_next  = slope_y_reg;
        decision_next = decision_reg;
        phase_next    = phase_reg;
        state_next    = state_reg;
        restart_next  = restart_reg;
        both_next     = both_reg;
        fin_next      = fin_reg;
        k_next        = k_reg;
        asq_next      = asq_reg;
        bsq_next      = bsq_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;

        // Configuration writes must come only while the sequencer is idle; the block does not enforce this.
        if (cfg_wr_en) begin
            unique case (cfg_index)
                mer_pkg::CFG_CENTER_X: center_x_next = cfg_wdata[CW-1:0];
                mer_pkg::CFG_CENTER_Y: center_y_next = cfg_wdata[CW-1:0];
                mer_pkg::CFG_RADIUS_X: radius_x_next = cfg_wdata[RADIUS_BITS-1:0];
                mer_pkg::CFG_RADIUS_Y: radius_y_next = cfg_wdata[RADIUS_BITS-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                // An advance after the end is consumed without any work.
                if (s_tvalid && (s_tdata[0] || (phase_reg != mer_pkg::PH_DONE))) begin
                    restart_next = s_tdata[0];
                    state_next   = ST_SQ_A;
                end
            end
            ST_SQ_A: begin
                asq_next   = mul_p[SQ_W-1:0];
                state_next = ST_SQ_B;
            end
            ST_SQ_B: begin
                bsq_next   = mul_p[SQ_W-1:0];
                state_next = restart_reg ? ST_R_AB : ST_STEP_A;
            end
            ST_R_AB: begin
                prod_next  = mul_dec;
                state_next = ST_R_AAB;
            end
            ST_R_AAB: begin
                prod_next  = mul_dec;
                state_next = ST_R_INIT;
            end
            ST_R_INIT: begin
                // prod_reg holds a*a*b here.
                step_x_next   = '0;
                step_y_next   = STEP_BITS'(radius_y_reg);
                slope_x_next  = '0;
                slope_y_next  = {prod_reg[SLOPE_BITS-2:0], 1'b0};
                decision_next = bsq4 - p4 + asq1;
                phase_next    = mer_pkg::PH_R1;
                state_next    = ST_CHK;
            end
            ST_STEP_A: begin
                // Step the coordinates and slopes; remember whether both moved.
                if (phase_reg == mer_pkg::PH_R1) begin
                    step_x_next  = step_x_reg + 1'b1;
                    slope_x_next = slope_x_reg + bsq2_s;
                    both_next    = !dec_neg;
                    if (!dec_neg) begin
                        step_y_next  = step_y_reg - 1'b1;
                        slope_y_next = slope_y_reg - asq2_s;
                    end
                end else begin
                    step_y_next  = step_y_reg - 1'b1;
                    slope_y_next = slope_y_reg - asq2_s;
                    both_next    = dec_neg || (decision_reg == '0);
                    if (dec_neg || (decision_reg == '0)) begin
                        step_x_next  = step_x_reg + 1'b1;
                        slope_x_next = slope_x_reg + bsq2_s;
                    end
                end
                state_next = ST_STEP_B;
            end
            ST_STEP_B: begin
                // Decision update with the slopes already stepped.
                if (phase_reg == mer_pkg::PH_R1) begin
                    decision_next = decision_reg + bsq4 + sx4 - (both_reg ? sy4 : '0);
                end else begin
                    decision_next = decision_reg + asq4 - sy4 + (both_reg ? sx4 : '0);
                end
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if ((phase_reg == mer_pkg::PH_R1) && !(slope_x_reg < slope_y_reg)) begin
                    state_next = ST_SET_BT;
                end else begin
                    state_next = ST_FIN;
                end
            end
            // Region-two decision: (b*tx)^2 + 4*(a*ty)^2 - 4*(a*b)^2.
            ST_SET_BT: begin
                prod_next  = mul_dec;
                state_next = ST_SET_BT2;
            end
            ST_SET_BT2: begin
                prod_next  = mul_dec;
                state_next = ST_SET_AT;
            end
            ST_SET_AT: begin
                acc_next   = prod_reg;
                prod_next  = mul_dec;
                state_next = ST_SET_AT2;
            end
            ST_SET_AT2: begin
                prod_next  = mul_dec;
                state_next = ST_SET_AB;
            end
            ST_SET_AB: begin
                acc_next   = acc_reg + p4;
                prod_next  = mul_dec;
                state_next = ST_SET_AB2;
            end
            ST_SET_AB2: begin
                prod_next  = mul_dec;
                state_next = ST_SET_END;
            end
            ST_SET_END: begin
                decision_next = acc_reg - p4;
                phase_next    = mer_pkg::PH_R2;
                state_next    = ST_FIN;
            end
            ST_FIN: begin
                // The ellipse ends once region two reaches y of zero.
                if ((phase_reg == mer_pkg::PH_R2) && (step_y_reg <= 0)) begin
                    phase_next = mer_pkg::PH_DONE;
                    fin_next   = 1'b1;
                end else begin
                    fin_next   = 1'b0;
                end
                k_next     = 2'd0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_load) begin
                    k_next = k_reg + 1'b1;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: one mirrored point per load.
    always_comb begin
        m_x_next    = m_x_reg;
        m_y_next    = m_y_reg;
        m_last_next = m_last_reg;
        m_fin_next  = m_fin_reg;
        if (emit_load) begin
            m_valid_next = 1'b1;
            m_x_next     = k_reg[1] ? (cx_c - sx_c) : (cx_c + sx_c);
            m_y_next     = k_reg[0] ? (cy_c - sy_c) : (cy_c + sy_c);
            m_last_next  = emit_last;
            m_fin_next   = fin_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_x_reg <= RADIUS_BITS'(60);
            radius_y_reg <= RADIUS_BITS'(30);
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            slope_x_reg  <= '0;
            slope_y_reg  <= '0;
            decision_reg <= '0;
            phase_reg    <= mer_pkg::PH_DONE;
            state_reg    <= ST_IDLE;
            restart_reg  <= 1'b0;
            both_reg     <= 1'b0;
            fin_reg      <= 1'b0;
            k_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
            radius_x_reg <= radius_x_next;
            radius_y_reg <= radius_y_next;
            step_x_reg   <= step_x_next;
            step_y_reg   <= step_y_next;
            slope_x_reg  <= slope_x_next;
            slope_y_reg  <= slope_y_next;
            decision_reg <= decision_next;
            phase_reg    <= phase_next;
            state_reg    <= state_next;
            restart_reg  <= restart_next;
            both_reg     <= both_next;
            fin_reg      <= fin_next;
            k_reg        <= k_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        asq_reg    <= asq_next;
        bsq_reg    <= bsq_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        m_x_reg    <= m_x_next;
        m_y_reg    <= m_y_next;
        m_last_reg <= m_last_next;
        m_fin_reg  <= m_fin_next;
    end

    // A step flagged as finishing the ellipse has left the walk in its done phase.
    a_fin_means_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && fin_reg) |-> (phase_reg == mer_pkg::PH_DONE))
        else $error("finished step emitted while the walk is still active");

    // Region two never carries y below zero.
    a_r2_y_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == mer_pkg::PH_R2) |-> !step_y_reg[STEP_BITS-1])
        else $error("region two walked past y of zero");

    // A restart emits only its two axis points.
    a_restart_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && restart_reg) |-> (k_reg[1] == 1'b0))
        else $error("restart emitted more than two points");

    // Entering region two happens only from region one.
    a_r2_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SET_END) |-> (phase_reg == mer_pkg::PH_R1))
        else $error("region-two decision loaded outside region one");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the midpoint ellipse rasterizer top level.
// Depends on mer_pkg and midpoint_ellipse_rasterizer; it predicts every plotted point itself.
`timescale 1ns / 1ps

module testbench;

    localparam int COORD_W      = 13;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT  = 4000;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT      = 400;
    localparam int PHASE_ITEMS  = 60;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
        logic               fin;
    } point_t;

    // Clock, reset and the ports of the block.
    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = 8'd0;      // [0] restart
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [31:0]       m_tdata;               // [12:0] point_x, [25:13] point_y
    logic              m_tlast;               // last_of_step
    logic              m_tuser;               // finished
    logic              cfg_wr_en = 1'b0;
    mer_pkg::cfg_idx_t cfg_index = mer_pkg::CFG_CENTER_X;
    logic [11:0]       cfg_wdata = 12'd0;

    // Requests still to be offered and points still to arrive.
    bit     request_queue[$];
    point_t point_queue[$];

    int send_idle_pct = 27;
    int recv_idle_pct = 77;
    int error_count   = 0;
    int quiet_cycles  = 0;
    int hold_left     = 0;
    int points_seen   = 0;

    // Shadow copy of the registers and of the walk state.
    logic signed [11:0] center_x_cfg = 12'sd0;
    logic signed [11:0] center_y_cfg = 12'sd0;
    logic [9:0]         radius_x_cfg = 10'd60;
    logic [9:0]         radius_y_cfg = 10'd30;
    longint             walk_x       = 0;
    longint             walk_y       = 0;
    longint             slope_x      = 0;
    longint             slope_y      = 0;
    bit [63:0]          decision_q   = 64'd0;
    mer_pkg::phase_t    walk_phase   = mer_pkg::PH_DONE;

    midpoint_ellipse_rasterizer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic void push_point(longint x, longint y, bit last, bit fin);
        point_t p;
        p.x    = x[COORD_W-1:0];
        p.y    = y[COORD_W-1:0];
        p.last = last;
        p.fin  = fin;
        point_queue.push_back(p);
    endfunction

    // Moves from region one to region two when the slopes cross, and reports the end.
    function automatic bit close_regions(bit [63:0] asq, bit [63:0] bsq);
        bit [63:0] tx;
        bit [63:0] ty;
        if (walk_phase == mer_pkg::PH_R1 && !(slope_x < slope_y)) begin
            tx = 2 * walk_x + 1;
            ty = walk_y - 1;
            decision_q = bsq * tx * tx + 4 * asq * ty * ty - 4 * asq * bsq;
            walk_phase = mer_pkg::PH_R2;
        end
        if (walk_phase == mer_pkg::PH_R2 && walk_y <= 0) begin
            walk_phase = mer_pkg::PH_DONE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Takes one walk step for an accepted request and queues the points it plots.
    function automatic void predict_points(bit restart);
        bit [63:0] a;
        bit [63:0] b;
        bit [63:0] asq;
        bit [63:0] bsq;
        longint    cx;
        longint    cy;
        bit        fin;
        a   = radius_x_cfg;
        b   = radius_y_cfg;
        asq = a * a;
        bsq = b * b;
        cx  = longint'(center_x_cfg);
        cy  = longint'(center_y_cfg);
        if (restart) begin
            walk_x     = 0;
            walk_y     = longint'(b);
            slope_x    = 0;
            slope_y    = longint'(2 * asq * b);
            decision_q = 4 * bsq - 4 * asq * b + asq;
            walk_phase = mer_pkg::PH_R1;
            fin = close_regions(asq, bsq);
            push_point(cx, cy + walk_y, 1'b0, fin);
            push_point(cx, cy - walk_y, 1'b1, fin);
            return;
        end
        case (walk_phase)
            mer_pkg::PH_R1: begin
                walk_x  = walk_x + 1;
                slope_x = slope_x + longint'(2 * bsq);
                if (decision_q[63]) begin
                    decision_q = decision_q + 4 * bsq + 4 * slope_x;
                end else begin
                    walk_y     = walk_y - 1;
                    slope_y    = slope_y - longint'(2 * asq);
                    decision_q = decision_q + 4 * bsq + 4 * slope_x - 4 * slope_y;
                end
            end
            mer_pkg::PH_R2: begin
                walk_y  = walk_y - 1;
                slope_y = slope_y - longint'(2 * asq);
                if (!decision_q[63] && decision_q != 0) begin
                    decision_q = decision_q + 4 * asq - 4 * slope_y;
                end else begin
                    walk_x     = walk_x + 1;
                    slope_x    = slope_x + longint'(2 * bsq);
                    decision_q = decision_q + 4 * asq - 4 * slope_y + 4 * slope_x;
                end
            end
            default: return;
        endcase
        fin = close_regions(asq, bsq);
        push_point(cx + walk_x, cy + walk_y, 1'b0, fin);
        push_point(cx + walk_x, cy - walk_y, 1'b0, fin);
        push_point(cx - walk_x, cy + walk_y, 1'b0, fin);
        push_point(cx - walk_x, cy - walk_y, 1'b1, fin);
    endfunction

    // Request driver: offers queued requests and predicts each accepted one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_points(s_tdata[0]);
            end
            if (!s_tvalid || s_tready) begin
                if (request_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, request_queue.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Point monitor: checks each accepted point against the oldest prediction.
    always @(posedge aclk) begin
        point_t got;
        point_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[12:0], m_tdata[25:13], m_tlast, m_tuser};
                if (point_queue.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected point x=%0d y=%0d last=%0b fin=%0b", $time,
                             $signed(got.x), $signed(got.y), got.last, got.fin);
                end else begin
                    want = point_queue.pop_front();
                    if (got !== want) begin
                        error_count++;
                        $display(
                            "%0t: expected %0d,%0d last %0b fin %0b, got %0d,%0d last %0b fin %0b",
                            $time, $signed(want.x), $signed(want.y), want.last, want.fin,
                            $signed(got.x), $signed(got.y), got.last, got.fin);
                    end
                end
                points_seen++;
                // One long hold-off so the block backs up into its input.
                if (points_seen == HOLD_AT) begin
                    hold_left = LONG_HOLD;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any accepted request or point.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(mer_pkg::cfg_idx_t idx, logic [11:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            mer_pkg::CFG_CENTER_X: center_x_cfg = value;
            mer_pkg::CFG_CENTER_Y: center_y_cfg = value;
            mer_pkg::CFG_RADIUS_X: radius_x_cfg = value[9:0];
            mer_pkg::CFG_RADIUS_Y: radius_y_cfg = value[9:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all(logic [11:0] cx, logic [11:0] cy, logic [9:0] rx, logic [9:0] ry);
        write_reg(mer_pkg::CFG_CENTER_X, cx);
        write_reg(mer_pkg::CFG_CENTER_Y, cy);
        write_reg(mer_pkg::CFG_RADIUS_X, {2'b00, rx});
        write_reg(mer_pkg::CFG_RADIUS_Y, {2'b00, ry});
    endtask

    // Waits until every request is taken and every point has come, then lets the block settle.
    task automatic wait_idle();
        while (request_queue.size() != 0 || s_tvalid || point_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_bits(int count, bit value);
        repeat (count) request_queue.push_back(value);
    endtask

    // Mostly complete ellipses with a restart in front, the rest broken walks and noise.
    task automatic queue_ellipses(int budget);
        int n;
        int cnt;
        n = 0;
        while (n < budget) begin
            if ($urandom_range(0, 99) < 80) begin
                cnt = int'(radius_x_cfg) + int'(radius_y_cfg) + 1;
                if (cnt > budget - n) begin
                    cnt = budget - n;
                end
                request_queue.push_back(1'b1);
                queue_bits(cnt, 1'b0);
                queue_bits($urandom_range(0, 2), 1'b0);
                n += cnt + 1;
            end else if ($urandom_range(0, 1) == 0) begin
                request_queue.push_back(1'b1);
                cnt = $urandom_range(0, 6);
                queue_bits(cnt, 1'b0);
                n += cnt + 1;
            end else begin
                cnt = $urandom_range(1, 4);
                repeat (cnt) request_queue.push_back(1'($urandom_range(0, 1)));
                n += cnt;
            end
        end
    endtask

    initial begin
        logic [11:0] cx;
        logic [11:0] cy;
        logic [9:0]  rx;
        logic [9:0]  ry;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset registers: advances before any restart, then a walk cut short by a restart.
        queue_bits(2, 1'b0);
        request_queue.push_back(1'b1);
        queue_bits(3, 1'b0);
        request_queue.push_back(1'b1);
        request_queue.push_back(1'b0);
        wait_idle();

        // Extreme centers with zero radii: the restart itself ends the ellipse.
        write_all(12'h7FF, 12'h800, 10'd0, 10'd0);
        request_queue.push_back(1'b1);
        request_queue.push_back(1'b0);
        wait_idle();

        // Zero radius along x: region two steps y alone and x stays at zero.
        write_all(12'h800, 12'h7FF, 10'd0, 10'd3);
        request_queue.push_back(1'b1);
        queue_bits(5, 1'b0);
        wait_idle();

        // Largest radii, first few steps only.
        write_all(12'h800, 12'h7FF, 10'd1023, 10'd1023);
        request_queue.push_back(1'b1);
        queue_bits(2, 1'b0);
        wait_idle();

        // A small complete ellipse off the origin.
        write_all(12'd5, -12'sd7, 10'd2, 10'd2);
        request_queue.push_back(1'b1);
        queue_bits(6, 1'b0);
        wait_idle();

        // Random phases, each with fresh register values; pairs of phases share an idling mode.
        for (int p = 0; p < 6; p++) begin
            if (p < 2) begin
                send_idle_pct = 27;
                recv_idle_pct = 77;
            end else if (p < 4) begin
                send_idle_pct = 77;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            cx = 12'($urandom_range(0, 4095));
            cy = 12'($urandom_range(0, 4095));
            rx = 10'($urandom_range(0, 24));
            ry = 10'($urandom_range(0, 24));
            case (p)
                1: begin
                    cx = 12'h800;
                    cy = 12'h7FF;
                    rx = 10'd1023;
                    ry = 10'($urandom_range(0, 3));
                end
                3: rx = 10'd0;
                4: begin
                    cx = 12'h7FF;
                    cy = 12'h800;
                    ry = 10'd1023;
                end
                default: ;
            endcase
            write_all(cx, cy, rx, ry);
            queue_ellipses(PHASE_ITEMS);
            wait_idle();
        end

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: midpoint_ellipse_rasterizer.f
rtl/mer_pkg.sv
rtl/midpoint_ellipse_rasterizer.sv
tb/testbench.sv
